// File: design/swept_box_collision_slide_assert.svh
// assertion macros for the swept box collision block
`ifndef SWEPT_BOX_COLLISION_SLIDE_ASSERT_SVH
`define SWEPT_BOX_COLLISION_SLIDE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SBCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define SBCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBCS_ASSERT_IMP(lbl, ante, cons, msg)
`define SBCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/sbcs_pkg.sv
package sbcs_pkg;

    // fixed point defaults and field widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int FT_W          = 31;
    localparam int QUO_W         = 31;
    localparam int DEN_W         = 33;
    localparam int MAG_W         = 34;
    localparam int EDGE_W        = 34;
    localparam int DIV_W         = 64;
    localparam int DIV_LAT       = QUO_W + 1;

    localparam logic [FT_W-1:0] FRAME_TIME_RST = 31'd1092;

    // face normal codes
    localparam logic [2:0] NORMAL_NONE = 3'd0;
    localparam logic [2:0] NORMAL_MX   = 3'd1;
    localparam logic [2:0] NORMAL_PX   = 3'd2;
    localparam logic [2:0] NORMAL_MY   = 3'd3;
    localparam logic [2:0] NORMAL_PY   = 3'd4;

    // face side on one axis
    localparam logic SIDE_LOW  = 1'b0;
    localparam logic SIDE_HIGH = 1'b1;

    // per axis face candidate flags
    typedef struct packed {
        logic cand;
        logic sfail;
        logic side;
    } axis_ctl_t;

    // data that rides beside the dividers
    typedef struct packed {
        axis_ctl_t                 ctl_x;
        axis_ctl_t                 ctl_y;
        logic signed [31:0]        vel_x;
        logic signed [31:0]        vel_y;
        logic signed [31:0]        pos_x;
        logic signed [31:0]        pos_y;
        logic signed [EDGE_W-1:0]  lo_x;
        logic signed [EDGE_W-1:0]  hi_x;
        logic signed [EDGE_W-1:0]  lo_y;
        logic signed [EDGE_W-1:0]  hi_y;
    } side_t;

endpackage

// File: design/swept_box_collision_slide.sv
// swept box collision with slide, signed fixed point
// request channel: drive the ten box fields and pulse start; a request is
// taken at each clock edge with start high and busy low. busy stays low, so
// a new request may be given in every cycle.
// result channel: done is high for one cycle with hit, impact_time,
// slid_vel_x, slid_vel_y and normal_side; there is no way to hold it off,
// so the receiver must take it in that cycle.
// pipeline: one setup stage, 32 divider stages (range check plus one
// quotient bit per stage for the 31 bit time), one multiply stage, one span
// check stage and one output stage.
// throughput: one request per cycle, results in request order.
// config: frame_time is written over cfg_valid/cfg_ready/cfg_data; ready is
// always high. write it only with no request in flight.
// reset: all valid bits clear, nothing in flight, frame_time returns to 1092.
module swept_box_collision_slide #(
    parameter int FRAC_BITS = sbcs_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  mover_x,
    input  logic signed [31:0]  mover_y,
    input  logic [30:0]         mover_w,
    input  logic [30:0]         mover_h,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic signed [31:0]  obst_x,
    input  logic signed [31:0]  obst_y,
    input  logic [30:0]         obst_w,
    input  logic [30:0]         obst_h,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [30:0]         cfg_data,
    output logic                done,
    output logic                hit,
    output logic [30:0]         impact_time,
    output logic signed [31:0]  slid_vel_x,
    output logic signed [31:0]  slid_vel_y,
    output logic [2:0]          normal_side
);

`include "swept_box_collision_slide_assert.svh"

    localparam int SBW = $bits(sbcs_pkg::side_t);

    logic                               frame_time_reg;
    logic [sbcs_pkg::FT_W-1:0]          ft_reg;
    logic                               req_fire;
    logic                               su_valid;
    logic [sbcs_pkg::DIV_W-1:0]         su_num_x;
    logic [sbcs_pkg::DEN_W-1:0]         su_den_x;
    logic [sbcs_pkg::DIV_W-1:0]         su_num_y;
    logic [sbcs_pkg::DEN_W-1:0]         su_den_y;
    sbcs_pkg::side_t                    su_side;
    logic                               dx_valid;
    logic                               dy_valid;
    logic [sbcs_pkg::QUO_W-1:0]         dx_quo;
    logic [sbcs_pkg::QUO_W-1:0]         dy_quo;
    logic                               dx_ovf;
    logic                               dy_ovf;
    logic [SBW-1:0]                     dl_side;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign req_fire  = start && !busy;

    // frame time register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ft_reg         <= sbcs_pkg::FRAME_TIME_RST;
            frame_time_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ft_reg         <= cfg_data;
            frame_time_reg <= 1'b1;
        end
    end

    // edges, face choice and divider operands
    sbcs_setup #(
        .FRAC_BITS (FRAC_BITS)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_fire),
        .mover_x   (mover_x),
        .mover_y   (mover_y),
        .mover_w   (mover_w),
        .mover_h   (mover_h),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .obst_x    (obst_x),
        .obst_y    (obst_y),
        .obst_w    (obst_w),
        .obst_h    (obst_h),
        .out_valid (su_valid),
        .num_x     (su_num_x),
        .den_x     (su_den_x),
        .num_y     (su_num_y),
        .den_y     (su_den_y),
        .side_data (su_side)
    );

    // face time dividers, one per axis
    sbcs_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (su_valid),
        .num       (su_num_x),
        .den       (su_den_x),
        .out_valid (dx_valid),
        .quo       (dx_quo),
        .ovf       (dx_ovf)
    );

    sbcs_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (su_valid),
        .num       (su_num_y),
        .den       (su_den_y),
        .out_valid (dy_valid),
        .quo       (dy_quo),
        .ovf       (dy_ovf)
    );

    // side data aligned with the quotients
    sbcs_delay #(
        .W     (SBW),
        .DEPTH (sbcs_pkg::DIV_LAT)
    ) u_delay (
        .clk  (clk),
        .din  (su_side),
        .dout (dl_side)
    );

    // span test, face pick and slide
    sbcs_resolve #(
        .FRAC_BITS (FRAC_BITS)
    ) u_resolve (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (dx_valid),
        .quo_x       (dx_quo),
        .ovf_x       (dx_ovf),
        .quo_y       (dy_quo),
        .ovf_y       (dy_ovf),
        .side_data   (sbcs_pkg::side_t'(dl_side)),
        .frame_time  (ft_reg),
        .done        (done),
        .hit         (hit),
        .impact_time (impact_time),
        .slid_vel_x  (slid_vel_x),
        .slid_vel_y  (slid_vel_y),
        .normal_side (normal_side)
    );

    // checks
    `SBCS_ASSERT_IMP(a_div_lockstep, dx_valid || dy_valid, dx_valid && dy_valid, "divider valids split")
    `SBCS_ASSERT_IMP(a_hit_code, done, hit == (normal_side != sbcs_pkg::NORMAL_NONE), "hit and normal disagree")
    `SBCS_ASSERT_IMP(a_hit_time, done && hit, (impact_time != 31'd0) && (impact_time < ft_reg) && (frame_time_reg || (ft_reg == sbcs_pkg::FRAME_TIME_RST)), "hit time outside window")
    `SBCS_ASSERT_IMP(a_slide_x, done && ((normal_side == sbcs_pkg::NORMAL_MX) || (normal_side == sbcs_pkg::NORMAL_PX)), slid_vel_x == 32'sd0, "x normal kept x velocity")
    `SBCS_ASSERT_IMP(a_miss_time, done && !hit, impact_time == 31'd0, "miss with nonzero time")

endmodule

// File: design/sbcs_setup.sv
module sbcs_setup #(
    parameter int FRAC_BITS = sbcs_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [31:0]                  mover_x,
    input  logic signed [31:0]                  mover_y,
    input  logic [30:0]                         mover_w,
    input  logic [30:0]                         mover_h,
    input  logic signed [31:0]                  vel_x,
    input  logic signed [31:0]                  vel_y,
    input  logic signed [31:0]                  obst_x,
    input  logic signed [31:0]                  obst_y,
    input  logic [30:0]                         obst_w,
    input  logic [30:0]                         obst_h,
    output logic                                out_valid,
    output logic [sbcs_pkg::DIV_W-1:0]          num_x,
    output logic [sbcs_pkg::DEN_W-1:0]          den_x,
    output logic [sbcs_pkg::DIV_W-1:0]          num_y,
    output logic [sbcs_pkg::DEN_W-1:0]          den_y,
    output sbcs_pkg::side_t                     side_data
);

    localparam int EW = sbcs_pkg::EDGE_W;

    typedef struct packed {
        sbcs_pkg::axis_ctl_t              ctl;
        logic [sbcs_pkg::MAG_W-1:0]       mag;
        logic [sbcs_pkg::DEN_W-1:0]       den;
    } prep_t;

    // face choice, distance magnitude and doubled speed for one axis
    function automatic prep_t axis_prep(
        input logic signed [32:0]    a2,
        input logic signed [EW-1:0]  lo,
        input logic signed [EW-1:0]  hi,
        input logic signed [31:0]    d
    );
        prep_t              p;
        logic signed [EW:0] a_e;
        logic signed [EW:0] n_lo;
        logic signed [EW:0] n_hi;
        logic signed [32:0] d_e;
        logic signed [32:0] abs_d;
        logic               below;
        logic               above;
        a_e   = (EW+1)'(a2);
        n_lo  = (EW+1)'(lo) - a_e;
        n_hi  = a_e - (EW+1)'(hi);
        below = n_lo > 0;
        above = n_hi > 0;
        d_e   = 33'(d);
        abs_d = d[31] ? -d_e : d_e;
        p.ctl.cand  = (d != 32'sd0) && (below || above);
        p.ctl.side  = below ? sbcs_pkg::SIDE_LOW : sbcs_pkg::SIDE_HIGH;
        p.ctl.sfail = below ? d[31] : !d[31];
        p.mag = below ? sbcs_pkg::MAG_W'($unsigned(n_lo))
                      : sbcs_pkg::MAG_W'($unsigned(n_hi));
        p.den = {abs_d[31:0], 1'b0};
        return p;
    endfunction

    logic [31:0]            sw_x;
    logic [31:0]            sw_y;
    logic signed [EW-1:0]   lo_x;
    logic signed [EW-1:0]   hi_x;
    logic signed [EW-1:0]   lo_y;
    logic signed [EW-1:0]   hi_y;
    logic signed [32:0]     px2;
    logic signed [32:0]     py2;
    prep_t                  prep_x;
    prep_t                  prep_y;
    sbcs_pkg::side_t        sb_next;

    logic                               vld_reg;
    logic [sbcs_pkg::DIV_W-1:0]         num_x_reg;
    logic [sbcs_pkg::DEN_W-1:0]         den_x_reg;
    logic [sbcs_pkg::DIV_W-1:0]         num_y_reg;
    logic [sbcs_pkg::DEN_W-1:0]         den_y_reg;
    sbcs_pkg::side_t                    sb_reg;

    // grown box edges at doubled scale
    always_comb
    begin
        sw_x = {1'b0, mover_w} + {1'b0, obst_w};
        sw_y = {1'b0, mover_h} + {1'b0, obst_h};
        lo_x = (EW'(obst_x) <<< 1) - $signed(EW'(sw_x));
        hi_x = (EW'(obst_x) <<< 1) + $signed(EW'(sw_x));
        lo_y = (EW'(obst_y) <<< 1) - $signed(EW'(sw_y));
        hi_y = (EW'(obst_y) <<< 1) + $signed(EW'(sw_y));
        px2  = 33'(mover_x) <<< 1;
        py2  = 33'(mover_y) <<< 1;
        prep_x = axis_prep(px2, lo_x, hi_x, vel_x);
        prep_y = axis_prep(py2, lo_y, hi_y, vel_y);
        sb_next.ctl_x = prep_x.ctl;
        sb_next.ctl_y = prep_y.ctl;
        sb_next.vel_x = vel_x;
        sb_next.vel_y = vel_y;
        sb_next.pos_x = mover_x;
        sb_next.pos_y = mover_y;
        sb_next.lo_x  = lo_x;
        sb_next.hi_x  = hi_x;
        sb_next.lo_y  = lo_y;
        sb_next.hi_y  = hi_y;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        num_x_reg <= sbcs_pkg::DIV_W'(prep_x.mag) << FRAC_BITS;
        den_x_reg <= prep_x.den;
        num_y_reg <= sbcs_pkg::DIV_W'(prep_y.mag) << FRAC_BITS;
        den_y_reg <= prep_y.den;
        sb_reg    <= sb_next;
    end

    assign out_valid = vld_reg;
    assign num_x     = num_x_reg;
    assign den_x     = den_x_reg;
    assign num_y     = num_y_reg;
    assign den_y     = den_y_reg;
    assign side_data = sb_reg;

endmodule

// File: design/sbcs_div.sv
module sbcs_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [sbcs_pkg::DIV_W-1:0]      num,
    input  logic [sbcs_pkg::DEN_W-1:0]      den,
    output logic                            out_valid,
    output logic [sbcs_pkg::QUO_W-1:0]      quo,
    output logic                            ovf
);

    localparam int QW = sbcs_pkg::QUO_W;
    localparam int DW = sbcs_pkg::DIV_W;

    logic [DW-1:0]               rem_reg [0:QW];
    logic [sbcs_pkg::DEN_W-1:0]  den_reg [0:QW];
    logic [QW-1:0]               q_reg   [0:QW];
    logic                        ovf_reg [0:QW];
    logic                        vld_reg [0:QW];

    // first stage: quotient range check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        ovf_reg[0] <= num >= (DW'(den) << QW);
    end

    // one quotient bit per stage, msb first
    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic [DW-1:0] trial;
        logic          take;

        assign trial = DW'(den_reg[k-1]) << (QW - k);
        assign take  = rem_reg[k-1] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= take ? rem_reg[k-1] - trial : rem_reg[k-1];
            den_reg[k] <= den_reg[k-1];
            q_reg[k]   <= {q_reg[k-1][QW-2:0], take};
            ovf_reg[k] <= ovf_reg[k-1];
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = q_reg[QW];
    assign ovf       = ovf_reg[QW];

endmodule

// File: design/sbcs_delay.sv
module sbcs_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [0:DEPTH-1];

    // shift line matched to the divider latency
    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// File: design/sbcs_resolve.sv
module sbcs_resolve #(
    parameter int FRAC_BITS = sbcs_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [sbcs_pkg::QUO_W-1:0]      quo_x,
    input  logic                            ovf_x,
    input  logic [sbcs_pkg::QUO_W-1:0]      quo_y,
    input  logic                            ovf_y,
    input  sbcs_pkg::side_t                 side_data,
    input  logic [sbcs_pkg::FT_W-1:0]       frame_time,
    output logic                            done,
    output logic                            hit,
    output logic [30:0]                     impact_time,
    output logic signed [31:0]              slid_vel_x,
    output logic signed [31:0]              slid_vel_y,
    output logic [2:0]                      normal_side
);

    localparam int CW = 66;
    localparam int QW = sbcs_pkg::QUO_W;

    // multiply stage
    logic                   m_vld_reg;
    logic signed [63:0]     m_prod_x_reg;
    logic signed [63:0]     m_prod_y_reg;
    logic [QW-1:0]          m_qx_reg;
    logic [QW-1:0]          m_qy_reg;
    logic                   m_ovfx_reg;
    logic                   m_ovfy_reg;
    sbcs_pkg::side_t        m_sb_reg;

    // span stage
    logic                   s_vld_reg;
    logic                   s_okx_reg;
    logic                   s_ovx_reg;
    logic                   s_oky_reg;
    logic                   s_sidex_reg;
    logic                   s_sidey_reg;
    logic [QW-1:0]          s_qx_reg;
    logic [QW-1:0]          s_qy_reg;
    logic signed [31:0]     s_vx_reg;
    logic signed [31:0]     s_vy_reg;

    // output stage
    logic                   o_vld_reg;
    logic                   o_hit_reg;
    logic [QW-1:0]          o_t_reg;
    logic signed [31:0]     o_vx_reg;
    logic signed [31:0]     o_vy_reg;
    logic [2:0]             o_normal_reg;

    logic signed [CW-1:0]   cross_x;
    logic signed [CW-1:0]   cross_y;
    logic                   span_x;
    logic                   span_y;
    logic                   okx_next;
    logic                   ovx_next;
    logic                   oky_next;
    logic [2:0]             normal_sel;
    logic [QW-1:0]          t_sel;
    logic                   hit_next;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= in_valid;
            s_vld_reg <= m_vld_reg;
            o_vld_reg <= s_vld_reg;
        end
    end

    // crossing offset along the other axis
    always_ff @(posedge clk)
    begin
        m_prod_x_reg <= $signed({1'b0, quo_x}) * side_data.vel_y;
        m_prod_y_reg <= $signed({1'b0, quo_y}) * side_data.vel_x;
        m_qx_reg     <= quo_x;
        m_qy_reg     <= quo_y;
        m_ovfx_reg   <= ovf_x;
        m_ovfy_reg   <= ovf_y;
        m_sb_reg     <= side_data;
    end

    // crossing point strictly inside the other span
    always_comb
    begin
        cross_x = (CW'(m_sb_reg.pos_y) <<< 1) + (CW'(m_prod_x_reg >>> FRAC_BITS) <<< 1);
        cross_y = (CW'(m_sb_reg.pos_x) <<< 1) + (CW'(m_prod_y_reg >>> FRAC_BITS) <<< 1);
        span_x  = (cross_x > CW'(m_sb_reg.lo_y)) && (cross_x < CW'(m_sb_reg.hi_y));
        span_y  = (cross_y > CW'(m_sb_reg.lo_x)) && (cross_y < CW'(m_sb_reg.hi_x));
        ovx_next = m_sb_reg.ctl_x.cand && !m_sb_reg.ctl_x.sfail && m_ovfx_reg;
        okx_next = m_sb_reg.ctl_x.cand && !m_sb_reg.ctl_x.sfail && !m_ovfx_reg && span_x;
        oky_next = m_sb_reg.ctl_y.cand && !m_sb_reg.ctl_y.sfail && !m_ovfy_reg && span_y;
    end

    always_ff @(posedge clk)
    begin
        s_okx_reg   <= okx_next;
        s_ovx_reg   <= ovx_next;
        s_oky_reg   <= oky_next;
        s_sidex_reg <= m_sb_reg.ctl_x.side;
        s_sidey_reg <= m_sb_reg.ctl_y.side;
        s_qx_reg    <= m_qx_reg;
        s_qy_reg    <= m_qy_reg;
        s_vx_reg    <= m_sb_reg.vel_x;
        s_vy_reg    <= m_sb_reg.vel_y;
    end

    // x face first, y face unless x overflowed, then the time window
    always_comb
    begin
        normal_sel = sbcs_pkg::NORMAL_NONE;
        t_sel      = '0;
        if (s_okx_reg)
        begin
            normal_sel = (s_sidex_reg == sbcs_pkg::SIDE_HIGH) ? sbcs_pkg::NORMAL_PX
                                                               : sbcs_pkg::NORMAL_MX;
            t_sel      = s_qx_reg;
        end
        else if (!s_ovx_reg && s_oky_reg)
        begin
            normal_sel = (s_sidey_reg == sbcs_pkg::SIDE_HIGH) ? sbcs_pkg::NORMAL_PY
                                                               : sbcs_pkg::NORMAL_MY;
            t_sel      = s_qy_reg;
        end
        hit_next = (normal_sel != sbcs_pkg::NORMAL_NONE) && (t_sel != '0)
                   && (t_sel < frame_time);
    end

    always_ff @(posedge clk)
    begin
        o_hit_reg    <= hit_next;
        o_t_reg      <= hit_next ? t_sel : '0;
        o_normal_reg <= hit_next ? normal_sel : sbcs_pkg::NORMAL_NONE;
        o_vx_reg     <= (hit_next && (normal_sel == sbcs_pkg::NORMAL_MX
                                      || normal_sel == sbcs_pkg::NORMAL_PX)) ? 32'sd0 : s_vx_reg;
        o_vy_reg     <= (hit_next && (normal_sel == sbcs_pkg::NORMAL_MY
                                      || normal_sel == sbcs_pkg::NORMAL_PY)) ? 32'sd0 : s_vy_reg;
    end

    assign done        = o_vld_reg;
    assign hit         = o_hit_reg;
    assign impact_time = o_t_reg;
    assign slid_vel_x  = o_vx_reg;
    assign slid_vel_y  = o_vy_reg;
    assign normal_side = o_normal_reg;

endmodule
